// File: hdl/lgge_pkg.sv
// ----------------------------------------------------------------------------
// lgge_pkg
// Shared types and codes for the life grid generation engine: operation
// codes, rule constants and the three-column neighborhood window passed to the rule unit.
// ----------------------------------------------------------------------------
package lgge_pkg;

  // operation codes carried in the input tuser field
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  // rule constants (B3/S23)
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // one column slice: bit 0 is the row above the page, bits 8:1 the page,
  // bit 9 the row below the page
  typedef logic [9:0] col_slice_t;

  // left, center and right column slices around the cell being evaluated
  typedef struct packed {
    col_slice_t lft;
    col_slice_t mid;
    col_slice_t rgt;
  } win_t;

endpackage

// File: hdl/lgge_rule.sv
// ----------------------------------------------------------------------------
// lgge_rule
// Shared cell evaluation unit: counts the eight neighbors of one cell in
// the current window and applies the B3/S23 rule.
// ----------------------------------------------------------------------------
module lgge_rule (
  input  lgge_pkg::win_t win_i,   // three column slices around the page
  input  logic [2:0]     sel_i,   // bit of the page under evaluation
  output logic           live_o   // next state of that cell
);

  logic [9:0] lft_sh;
  logic [9:0] mid_sh;
  logic [9:0] rgt_sh;
  logic [3:0] nbr_cnt;

  // align the 3x3 neighborhood to the low bits
  assign lft_sh = win_i.lft >> sel_i;
  assign mid_sh = win_i.mid >> sel_i;
  assign rgt_sh = win_i.rgt >> sel_i;

  // neighbor count, center excluded
  assign nbr_cnt = 4'(lft_sh[0]) + 4'(lft_sh[1]) + 4'(lft_sh[2])
                 + 4'(mid_sh[0]) + 4'(mid_sh[2])
                 + 4'(rgt_sh[0]) + 4'(rgt_sh[1]) + 4'(rgt_sh[2]);

  // birth on three, survival on two or three
  assign live_o = (nbr_cnt == lgge_pkg::BIRTH_COUNT)
               || (mid_sh[1] && (nbr_cnt == lgge_pkg::SURVIVE_COUNT));

endmodule

// File: hdl/life_grid_generation_engine_core.sv
// ----------------------------------------------------------------------------
// life_grid_generation_engine_core
// Conway Life (B3/S23) engine over two page-packed bit grids with no wrap.
// ----------------------------------------------------------------------------
// Both grids live in one simple dual-port byte memory (one write, one
// registered read per cycle), eight vertical cells to a byte. After reset a
// clearing pass zeroes the current grid, one byte a cycle; no input is taken
// meanwhile. The other grid needs no clearing since a generation rewrites
// every byte of it before it becomes current. A cell write or read passes
// from acceptance through the read, write-back and finish states before its
// result is registered. A generation sweeps each page column by column
// through a single cell evaluation unit, one cell per cycle, with the three
// reads of the next column overlapped. One transaction is worked on at a
// time; the finished result sits in an output register so the next
// transaction can be accepted while it waits.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_core #(
  parameter int GRID_WIDTH  = 128,
  parameter int GRID_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input transactions
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // col [6:0], row [12:7], cell_in [13], zero [15:14]
  input  logic [1:0]  s_axis_tuser,   // op [1:0]
  // result transactions
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // cell_out [0], zero [7:1]
  output logic [1:0]  m_axis_tuser    // done_op [1:0]
);

  localparam int PAGES  = (GRID_HEIGHT + 7) / 8;
  localparam int GBYTES = GRID_WIDTH * PAGES;
  localparam int AW     = $clog2(GBYTES);
  localparam int MAW    = AW + 1;
  localparam int PGW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CW     = $clog2(GRID_WIDTH + 2);
  localparam logic [AW-1:0] WSTEP    = AW'(GRID_WIDTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(GBYTES - 1);
  localparam logic [CW-1:0] K_LAST   = CW'(GRID_WIDTH + 1);
  localparam logic [CW-1:0] K_FIRST  = CW'(2);
  localparam logic [PGW-1:0] PG_LAST = PGW'(PAGES - 1);

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CRD   = 3'd2;
  localparam logic [2:0] ST_CWB   = 3'd3;
  localparam logic [2:0] ST_GEN   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]     state_q, state_d;
  logic           sel_q, sel_d;
  logic [PGW-1:0] pg_q, pg_d;
  logic [CW-1:0]  k_q, k_d;
  logic [2:0]     ph_q, ph_d;
  logic [AW-1:0]  pbase_q, pbase_d;
  logic [AW-1:0]  clr_q, clr_d;
  lgge_pkg::win_t win_q, win_d;
  logic [9:0]     stg_q, stg_d;
  logic [6:0]     obyte_q, obyte_d;
  logic [1:0]     op_q, op_d;
  logic [6:0]     col_q, col_d;
  logic [5:0]     row_q, row_d;
  logic           cin_q, cin_d;
  logic           res_cell_q, res_cell_d;
  logic           out_vld_q, out_vld_d;
  logic           out_cell_q, out_cell_d;
  logic [1:0]     out_op_q, out_op_d;

  // grid memory: {grid select, byte address}
  logic [7:0]     grid_mem_q [0:(1 << MAW) - 1];
  logic [7:0]     rdata_q;
  logic           mem_we;
  logic [MAW-1:0] mem_waddr;
  logic [7:0]     mem_wdata;
  logic [MAW-1:0] mem_raddr;

  // derived terms
  logic           in_txn;
  logic           out_free;
  logic           cell_on_grid;
  logic [AW-1:0]  cell_byte;
  logic [7:0]     cell_mask;
  logic           col_loaded;
  logic           has_up;
  logic           has_dn;
  logic           row_ok;
  logic           cell_live;
  logic [AW-1:0]  cur_addr;

  assign in_txn   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  // cell addressing for write and read transactions
  assign cell_on_grid = (9'(col_q) < 9'(GRID_WIDTH)) && (9'(row_q) < 9'(GRID_HEIGHT));
  assign cell_byte    = AW'(col_q) + AW'(row_q[5:3]) * WSTEP;
  assign cell_mask    = 8'(1) << row_q[2:0];

  // generation sweep terms
  assign col_loaded = 9'(k_q) < 9'(GRID_WIDTH);
  assign has_up     = (pg_q != '0);
  assign has_dn     = (pg_q != PG_LAST);
  assign row_ok     = 9'({pg_q, ph_q}) < 9'(GRID_HEIGHT);
  assign cur_addr   = pbase_q + AW'(k_q);

  // shared cell evaluation unit
  lgge_rule u_rule (
    .win_i  (win_q),
    .sel_i  (ph_q),
    .live_o (cell_live)
  );

  // sequencer and memory controls
  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    pg_d       = pg_q;
    k_d        = k_q;
    ph_d       = ph_q;
    pbase_d    = pbase_q;
    clr_d      = clr_q;
    win_d      = win_q;
    stg_d      = stg_q;
    obyte_d    = obyte_q;
    op_d       = op_q;
    col_d      = col_q;
    row_d      = row_q;
    cin_d      = cin_q;
    res_cell_d = res_cell_q;
    out_vld_d  = out_vld_q;
    out_cell_d = out_cell_q;
    out_op_d   = out_op_q;
    mem_we     = 1'b0;
    mem_waddr  = {sel_q, cell_byte};
    mem_wdata  = '0;
    mem_raddr  = {sel_q, cell_byte};

    // output register drains independently
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {1'b0, clr_q};
        clr_d     = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_txn) begin
          op_d       = s_axis_tuser;
          col_d      = s_axis_tdata[6:0];
          row_d      = s_axis_tdata[12:7];
          cin_d      = s_axis_tdata[13];
          res_cell_d = 1'b0;
          pg_d       = '0;
          k_d        = '0;
          ph_d       = '0;
          pbase_d    = '0;
          win_d      = '0;
          unique case (s_axis_tuser)
            lgge_pkg::OP_WRITE, lgge_pkg::OP_READ: state_d = ST_CRD;
            lgge_pkg::OP_STEP:                     state_d = ST_GEN;
            default:                               state_d = ST_FIN;
          endcase
        end
      end
      ST_CRD: begin
        // byte read issued here, data back next cycle
        state_d = ST_CWB;
      end
      ST_CWB: begin
        if (op_q == lgge_pkg::OP_WRITE) begin
          mem_we    = cell_on_grid;
          mem_wdata = cin_q ? (rdata_q | cell_mask) : (rdata_q & ~cell_mask);
        end else begin
          res_cell_d = cell_on_grid && rdata_q[row_q[2:0]];
        end
        state_d = ST_FIN;
      end
      ST_GEN: begin
        // fetch the next column: page above, page, page below
        unique case (ph_q)
          3'd0:    mem_raddr = {sel_q, cur_addr - WSTEP};
          3'd1:    mem_raddr = {sel_q, cur_addr};
          default: mem_raddr = {sel_q, cur_addr + WSTEP};
        endcase
        if (ph_q == 3'd1) begin
          stg_d[0] = col_loaded && has_up && rdata_q[7];
        end
        if (ph_q == 3'd2) begin
          stg_d[8:1] = col_loaded ? rdata_q : 8'd0;
        end
        if (ph_q == 3'd3) begin
          stg_d[9] = col_loaded && has_dn && rdata_q[0];
        end

        // one cell per phase into the output byte
        if (ph_q != 3'd7) begin
          obyte_d[ph_q] = cell_live && row_ok;
        end

        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd7) begin
          mem_we    = (k_q >= K_FIRST);
          mem_waddr = {~sel_q, cur_addr - AW'(2)};
          mem_wdata = {cell_live && row_ok, obyte_q};
          win_d.lft = win_q.mid;
          win_d.mid = win_q.rgt;
          win_d.rgt = stg_q;
          k_d       = k_q + CW'(1);
          if (k_q == K_LAST) begin
            k_d     = '0;
            win_d   = '0;
            pg_d    = pg_q + PGW'(1);
            pbase_d = pbase_q + WSTEP;
            if (pg_q == PG_LAST) begin
              sel_d   = ~sel_q;
              state_d = ST_FIN;
            end
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_cell_d = res_cell_q;
          out_op_d   = op_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      sel_q     <= 1'b0;
      pg_q      <= '0;
      k_q       <= '0;
      ph_q      <= '0;
      pbase_q   <= '0;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      sel_q     <= sel_d;
      pg_q      <= pg_d;
      k_q       <= k_d;
      ph_q      <= ph_d;
      pbase_q   <= pbase_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    win_q      <= win_d;
    stg_q      <= stg_d;
    obyte_q    <= obyte_d;
    op_q       <= op_d;
    col_q      <= col_d;
    row_q      <= row_d;
    cin_q      <= cin_d;
    res_cell_q <= res_cell_d;
    out_cell_q <= out_cell_d;
    out_op_q   <= out_op_d;
  end

  // grid memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= grid_mem_q[mem_raddr];
  end

  // ports
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_cell_q};
  assign m_axis_tuser  = out_op_q;

`ifndef NO_ASSERTIONS
  // a generation never writes into the grid it is reading
  a_gen_other_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GEN && mem_we) |-> (mem_waddr[AW] != sel_q))
    else $error("generation write targets the current grid");

  // the grid select only flips as a generation finishes
  a_sel_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_q != $past(sel_q)) |-> ($past(state_q) == ST_GEN && state_q == ST_FIN))
    else $error("grid select changed outside a generation");

  // sweep counters stay within the grid
  a_sweep_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GEN) |-> (k_q <= K_LAST && 9'(pg_q) < 9'(PAGES)))
    else $error("generation sweep counter out of range");

  // a finished transaction reaches the output register once it is free
  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free) |=> (m_axis_tvalid && state_q == ST_IDLE))
    else $error("result not presented after completion");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the life grid generation engine. Cell writes,
// cell reads, generation steps and the unused op code are streamed into the
// core. A local copy of both grids predicts every result, and each result is
// compared field by field in arrival order. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int GRID_W = 128;
  localparam int GRID_H = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 75;
  // covers the clearing pass plus at most ~30 generations
  localparam int CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    logic       cell_out;
    logic [1:0] done_op;
  } life_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // col [6:0], row [12:7], cell_in [13], zero [15:14]
  logic [1:0]  s_axis_tuser;   // op [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;   // cell_out [0], zero [7:1]
  logic [1:0]  m_axis_tuser;   // done_op [1:0]

  // local copy of both grids, one packed vector per column
  logic [GRID_H-1:0] life_cols [2][GRID_W];
  bit                active_grid;

  life_result_t pending_results [$];
  life_result_t oldest_result;
  int           mismatch_count = 0;
  int           items_sent;
  int           cycle_count = 0;
  bit           no_idle;

  life_grid_generation_engine_core #(
    .GRID_WIDTH (GRID_W),
    .GRID_HEIGHT(GRID_H)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // clock, 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // cells off the grid read as dead
  function automatic bit cell_at(bit g, int x, int y);
    if (x < 0 || x >= GRID_W || y < 0 || y >= GRID_H) return 1'b0;
    return life_cols[g][x][y];
  endfunction

  // one B3/S23 generation into the other grid, then swap
  function automatic void advance_generation();
    bit cur;
    int n;
    bit alive;
    cur = active_grid;
    for (int x = 0; x < GRID_W; x++) begin
      for (int y = 0; y < GRID_H; y++) begin
        n = 0;
        for (int dx = -1; dx <= 1; dx++) begin
          for (int dy = -1; dy <= 1; dy++) begin
            if (dx != 0 || dy != 0) n += int'(cell_at(cur, x + dx, y + dy));
          end
        end
        alive = cell_at(cur, x, y);
        life_cols[!cur][x][y] = (n == 3) || (alive && n == 2);
      end
    end
    active_grid = !cur;
  endfunction

  // apply one transaction to the local grids and return its result
  function automatic life_result_t predict_result(logic [1:0] op, logic [6:0] col,
                                                  logic [5:0] row, logic live);
    life_result_t r;
    r.cell_out = 1'b0;
    r.done_op  = op;
    case (op)
      lgge_pkg::OP_WRITE: begin
        if (int'(col) < GRID_W && int'(row) < GRID_H)
          life_cols[active_grid][col][row] = live;
      end
      lgge_pkg::OP_READ: begin
        r.cell_out = cell_at(active_grid, int'(col), int'(row));
      end
      lgge_pkg::OP_STEP: begin
        advance_generation();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // send one transaction, with an occasional gap ahead of it
  task automatic send_item(input logic [1:0] op, input logic [6:0] col,
                           input logic [5:0] row, input logic live);
    if (!no_idle && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, live, row, col};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_result(op, col, row, live));
    items_sent++;
  endtask

  // result side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 20);
  end

  // compare each result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: tdata %h tuser %0d", m_axis_tdata, m_axis_tuser);
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_axis_tdata !== {7'b0, oldest_result.cell_out} ||
            m_axis_tuser !== oldest_result.done_op) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: cell_out exp %0d got %0d, done_op exp %0d got %0d",
                     oldest_result.cell_out, m_axis_tdata[0],
                     oldest_result.done_op, m_axis_tuser);
          if (mismatch_count <= 10 && m_axis_tdata[7:1] !== 7'b0)
            $display("mismatch: padding bits of tdata %h not zero", m_axis_tdata);
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // the current grid reads back dead after the clearing pass
  task automatic test_clear_after_reset();
    send_item(lgge_pkg::OP_READ, 7'd0, 6'd0, 1'b0);
    send_item(lgge_pkg::OP_READ, 7'd127, 6'd63, 1'b1);
    send_item(lgge_pkg::OP_READ, 7'd64, 6'd32, 1'b0);
  endtask

  // write and read back the four corners, then kill one
  task automatic test_corner_cells();
    send_item(lgge_pkg::OP_WRITE, 7'd0, 6'd0, 1'b1);
    send_item(lgge_pkg::OP_WRITE, 7'd127, 6'd63, 1'b1);
    send_item(lgge_pkg::OP_WRITE, 7'd127, 6'd0, 1'b1);
    send_item(lgge_pkg::OP_WRITE, 7'd0, 6'd63, 1'b1);
    send_item(lgge_pkg::OP_READ, 7'd0, 6'd0, 1'b0);
    send_item(lgge_pkg::OP_READ, 7'd127, 6'd63, 1'b0);
    send_item(lgge_pkg::OP_READ, 7'd127, 6'd0, 1'b0);
    send_item(lgge_pkg::OP_READ, 7'd0, 6'd63, 1'b0);
    send_item(lgge_pkg::OP_WRITE, 7'd127, 6'd0, 1'b0);
    send_item(lgge_pkg::OP_READ, 7'd127, 6'd0, 1'b1);
  endtask

  // unused op code changes nothing and reads as dead
  task automatic test_unused_op();
    send_item(OP_UNUSED, 7'd127, 6'd63, 1'b1);
  endtask

  // vertical blinker across a page boundary on the left edge
  task automatic test_blinker_page_edge();
    send_item(lgge_pkg::OP_WRITE, 7'd0, 6'd7, 1'b1);
    send_item(lgge_pkg::OP_WRITE, 7'd0, 6'd8, 1'b1);
    send_item(lgge_pkg::OP_WRITE, 7'd0, 6'd9, 1'b1);
    send_item(lgge_pkg::OP_STEP, 7'd0, 6'd0, 1'b0);
    send_item(lgge_pkg::OP_READ, 7'd1, 6'd8, 1'b0);
    send_item(lgge_pkg::OP_READ, 7'd0, 6'd7, 1'b0);
    send_item(lgge_pkg::OP_READ, 7'd0, 6'd0, 1'b0);
    send_item(lgge_pkg::OP_STEP, 7'd127, 6'd63, 1'b1);
    send_item(lgge_pkg::OP_READ, 7'd0, 6'd7, 1'b0);
  endtask

  function automatic int pick_near(int base, int hi);
    int lo_c;
    int hi_c;
    lo_c = (base > 2) ? base - 2 : 0;
    hi_c = (base + 2 < hi) ? base + 2 : hi;
    return $urandom_range(hi_c, lo_c);
  endfunction

  // seed small patterns near edges and page boundaries, step, read back; some episodes send noise instead
  task automatic test_random_episodes();
    int col_base;
    int row_base;
    int start;
    int ep;
    logic [1:0] op;
    start = items_sent;
    ep = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      no_idle = (ep >= 2 && ep <= 4);
      case ($urandom_range(3))
        0: col_base = 0;
        1: col_base = GRID_W - 1;
        default: col_base = $urandom_range(GRID_W - 1);
      endcase
      case ($urandom_range(3))
        0: row_base = 0;
        1: row_base = GRID_H - 1;
        2: row_base = 8 * $urandom_range(GRID_H / 8 - 1, 1);
        default: row_base = $urandom_range(GRID_H - 1);
      endcase
      if ($urandom_range(99) < 85) begin
        repeat ($urandom_range(9, 3))
          send_item(lgge_pkg::OP_WRITE, 7'(pick_near(col_base, GRID_W - 1)),
                    6'(pick_near(row_base, GRID_H - 1)), $urandom_range(99) < 75);
        repeat ($urandom_range(2, 1))
          send_item(lgge_pkg::OP_STEP, 7'($urandom_range(127)), 6'($urandom_range(63)),
                    1'($urandom_range(1)));
        repeat ($urandom_range(6, 3))
          send_item(lgge_pkg::OP_READ, 7'(pick_near(col_base, GRID_W - 1)),
                    6'(pick_near(row_base, GRID_H - 1)), 1'($urandom_range(1)));
      end else begin
        // noise over the whole field range
        repeat ($urandom_range(4, 1)) begin
          case ($urandom_range(2))
            0: op = lgge_pkg::OP_WRITE;
            1: op = lgge_pkg::OP_READ;
            default: op = OP_UNUSED;
          endcase
          send_item(op, 7'($urandom_range(127)), 6'($urandom_range(63)),
                    1'($urandom_range(1)));
        end
      end
      ep++;
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = lgge_pkg::OP_WRITE;
    no_idle        = 1'b0;
    items_sent     = 0;
    active_grid    = 1'b0;
    for (int g = 0; g < 2; g++) begin
      for (int x = 0; x < GRID_W; x++) life_cols[g][x] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_clear_after_reset();
    test_corner_cells();
    test_unused_op();
    test_blinker_page_edge();
    test_random_episodes();
    s_axis_tvalid <= 1'b0;

    // drain, then watch for stray results
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
